[rtl/prq_pkg.sv]
// Shared types and constants for the priority ready queue.
// No dependencies; imported by every module of the block.
package prq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PRIO_BITS   = 8;
  localparam int ID_W        = 4;
  localparam int IN_PRIO_W   = 8;
  localparam int COUNT_OUT_W = 5;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_POP     = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_REQUEUE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_DUP_FULL  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Per-cell command broadcast along the row
  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_SHIFT = 2'd1,
    CMD_PLACE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e             op;
    logic [ID_W-1:0]      id;
    logic [PRIO_BITS-1:0] prio;
  } cell_cmd_t;

endpackage

[rtl/prq_cell.sv]
// One slot of the sorted ready list: holds an id and a priority.
// Depends on prq_pkg; instantiated in a row by priority_ready_queue_top.
module prq_cell
  import prq_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      occ_i,         // slot lies below the entry count
  input  entry_t    prev_entry_i,  // neighbor nearer the head
  input  logic      prev_le_i,     // neighbor stays put on placement
  input  entry_t    next_entry_i,  // neighbor nearer the tail
  input  logic      hit_i,         // id matched at or before the previous slot
  output entry_t    entry_o,
  output logic      le_o,
  output logic      hit_o
);

  entry_t entry_q, entry_d;
  logic   match;

  assign match   = occ_i && (entry_q.id == cmd_i.id);
  assign hit_o   = hit_i || match;
  assign le_o    = occ_i && (entry_q.prio <= cmd_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      CMD_HOLD: entry_d = entry_q;
      CMD_SHIFT: begin
        // close the gap left by the removed entry
        if (hit_o) entry_d = next_entry_i;
      end
      CMD_PLACE: begin
        // first slot past the equal-or-more-urgent run takes the new entry; later slots take their head-side neighbor
        if (!le_o) begin
          if (prev_le_i) begin
            entry_d.id   = cmd_i.id;
            entry_d.prio = cmd_i.prio;
          end else begin
            entry_d = prev_entry_i;
          end
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[rtl/priority_ready_queue_top.sv]
// Top level of the priority ready queue: control sequencer, cell row, result register.
// Depends on prq_pkg and prq_cell.
//
// Sorted task ready list, lower priority value first, equal priorities in
// arrival order. One action per input transfer (insert, pop head, remove id,
// requeue id with a new priority); each yields exactly one result transfer with
// a status, the popped id, the head after the action and the entry count.
// Items are handled one at a time. Pop and remove pass through the id search
// state (S_FIND) and the result state (S_DONE); insert and requeue also pass
// through S_PLACE between them, since the placement is a second pass over the
// cell row after the id search/removal pass. A rejected insert or a requeue of
// an absent id skips placement. s_axis_tready comes back in the same cycle that
// the result appears in the output register. In each pass every cell compares
// its entry against the broadcast id or priority and loads from a neighbor or
// takes the broadcast entry, with the id-hit flag rippling down the row.
// s_axis_tready is high whenever no item is in progress; a waiting result sits
// in the output register and does not block the next transfer, but its own
// result waits until the previous one is taken. No clearing pass after reset:
// only slots below the entry count are ever looked at.
module priority_ready_queue_top
  import prq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // task_id[3:0], task_prio[11:4], zero pad
  input  logic [1:0]            s_axis_tuser,   // action[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // popped_id[3:0], head_valid[4],
                                                // head_id[8:5], entry_count[13:9], pad
  output logic [1:0]            m_axis_tuser    // status[1:0]
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIND  = 4'b0010,
    S_PLACE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  action_e               act_q, act_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [PRIO_BITS-1:0]  prio_q, prio_d;
  status_e               status_q, status_d;
  logic [ID_W-1:0]       popped_q, popped_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [1:0]            m_user_q, m_user_d;

  cell_cmd_t             cmd;
  entry_t                entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ, le, hit;

  logic in_xfer, out_free, found, full, shift_en;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign found    = hit[QUEUE_DEPTH-1];
  assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---------------- cell row ----------------
  assign cmd.op   = shift_en ? CMD_SHIFT : ((state_q == S_PLACE) ? CMD_PLACE : CMD_HOLD);
  assign cmd.id   = id_q;
  assign cmd.prio = prio_q;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_le, prev_hit;

    assign occ[i] = (CNT_W'(i) < cnt_q);

    if (i == 0) begin : g_head
      assign prev_e   = '0;
      assign prev_le  = 1'b1;
      assign prev_hit = (act_q == ACT_POP);  // pop removes the head
    end else begin : g_body
      assign prev_e   = entry[i-1];
      assign prev_le  = le[i-1];
      assign prev_hit = hit[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = entry[i+1];
    end

    prq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[i]),
      .prev_entry_i (prev_e),
      .prev_le_i    (prev_le),
      .next_entry_i (next_e),
      .hit_i        (prev_hit),
      .entry_o      (entry[i]),
      .le_o         (le[i]),
      .hit_o        (hit[i])
    );
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    id_d      = id_q;
    prio_d    = prio_q;
    status_d  = status_q;
    popped_d  = popped_q;
    cnt_d     = cnt_q;
    shift_en  = 1'b0;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          act_d    = action_e'(s_axis_tuser);
          id_d     = s_axis_tdata[ID_W-1:0];
          prio_d   = PRIO_BITS'(s_axis_tdata[ID_W +: IN_PRIO_W]);
          status_d = ST_OK;
          popped_d = '0;
          state_d  = S_FIND;
        end
      end
      S_FIND: begin
        state_d = S_DONE;
        unique case (act_q)
          ACT_INSERT: begin
            if (full || found) status_d = ST_DUP_FULL;
            else               state_d  = S_PLACE;
          end
          ACT_POP: begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              popped_d = entry[0].id;
              shift_en = 1'b1;
              cnt_d    = cnt_q - CNT_W'(1);
            end
          end
          ACT_REMOVE, ACT_REQUEUE: begin
            if (!found) begin
              status_d = ST_NOT_FOUND;
            end else begin
              shift_en = 1'b1;
              cnt_d    = cnt_q - CNT_W'(1);
              if (act_q == ACT_REQUEUE) state_d = S_PLACE;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_PLACE: begin
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        // wait for the previous result to be taken
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = status_q;
          m_data_d  = '0;
          m_data_d[ID_W-1:0]             = popped_q;
          m_data_d[ID_W]                 = (cnt_q != '0);
          m_data_d[ID_W+1 +: ID_W]       = (cnt_q != '0) ? entry[0].id : '0;
          m_data_d[2*ID_W+1 +: COUNT_OUT_W] = COUNT_OUT_W'(cnt_q);
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    id_q     <= id_d;
    prio_q   <= prio_d;
    status_q <= status_d;
    popped_q <= popped_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

endmodule

[rtl/prq_checker.sv]
// Port-level checks for the priority ready queue, bound to the top level.
// Depends on prq_pkg and priority_ready_queue_top.
module prq_checker
  import prq_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ID_W] == (m_axis_tdata[2*ID_W+1 +: COUNT_OUT_W] != '0)))
    else $error("head_valid disagrees with entry count");

  a_null_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[ID_W] |-> (m_axis_tdata[ID_W+1 +: ID_W] == '0))
    else $error("empty list shows a non-null head");

  a_popped_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[ID_W-1:0] == '0))
    else $error("popped id on a failed action");

endmodule

bind priority_ready_queue_top prq_checker u_prq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[sim/testbench.sv]
// Self-checking bench for priority_ready_queue_top: stream driver, result monitor,
// and an in-bench sorted-list predictor. Depends on prq_pkg and the block's RTL.
module testbench;
  import prq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // No transfer on either side for this many cycles ends the run. The slowest
  // legal gap is set by the receiver's long hold (HOLD_CYCLES).
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 23;
  localparam int TOTAL_ITEMS = 1300;

  // One list action as offered on the input stream
  typedef struct packed {
    action_e              act;
    logic [ID_W-1:0]      id;
    logic [IN_PRIO_W-1:0] prio;
  } list_action_t;

  // One result as it should appear on the output stream
  typedef struct packed {
    status_e                status;
    logic [ID_W-1:0]        popped_id;
    logic                   head_valid;
    logic [ID_W-1:0]        head_id;
    logic [COUNT_OUT_W-1:0] entry_count;
  } list_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // task_id[3:0], task_prio[11:4], zero pad
  logic [1:0]            s_axis_tuser = '0;   // action[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // popped_id[3:0], head_valid[4],
                                              // head_id[8:5], entry_count[13:9], pad
  logic [1:0]            m_axis_tuser;        // status[1:0]

  priority_ready_queue_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Actions waiting to be offered, and results owed by the block, oldest first
  list_action_t queued_actions[$];
  list_result_t awaited_results[$];
  list_action_t on_bus;

  // Predicted ready list: head at index 0, ordered by priority then arrival
  logic [ID_W-1:0]      rl_id[QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] rl_prio[QUEUE_DEPTH];
  int                   rl_count = 0;

  // Stimulus shaping, set from the sequencing block at the falling edge
  logic steady = 1'b0;      // no idling on either side
  logic hold_req = 1'b0;    // ask the receiver for one long hold-off
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int errors = 0;
  int items_made = 0;
  int results_seen = 0;
  int peak_depth = 0;
  int quiet_cycles = 0;
  int act_seen[4];
  int status_seen[4];

  //--------------------------------------------------------------------------
  // Clock
  //--------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------
  // Position of id in the list, or rl_count when it is not queued
  function automatic int find_task(logic [ID_W-1:0] id);
    for (int i = 0; i < rl_count; i++) begin
      if (rl_id[i] == id) return i;
    end
    return rl_count;
  endfunction

  // Close the gap left by the entry at pos
  function automatic void slot_out(int pos);
    for (int i = pos; i + 1 < rl_count; i++) begin
      rl_id[i]   = rl_id[i+1];
      rl_prio[i] = rl_prio[i+1];
    end
    rl_count--;
  endfunction

  // Queue behind every entry of equal or more urgent priority (FIFO on ties)
  function automatic void slot_in(logic [ID_W-1:0] id, logic [PRIO_BITS-1:0] prio);
    int pos;
    pos = 0;
    while (pos < rl_count && rl_prio[pos] <= prio) pos++;
    for (int i = rl_count; i > pos; i--) begin
      rl_id[i]   = rl_id[i-1];
      rl_prio[i] = rl_prio[i-1];
    end
    rl_id[pos]   = id;
    rl_prio[pos] = prio;
    rl_count++;
  endfunction

  // Apply one action to the predicted list and return the result it owes
  function automatic list_result_t ready_list_step(list_action_t a);
    list_result_t         r;
    logic [PRIO_BITS-1:0] p;
    int                   pos;
    r = '0;
    r.status = ST_OK;
    p = a.prio[PRIO_BITS-1:0];
    case (a.act)
      ACT_INSERT: begin
        if (rl_count >= QUEUE_DEPTH || find_task(a.id) < rl_count) r.status = ST_DUP_FULL;
        else slot_in(a.id, p);
      end
      ACT_POP: begin
        if (rl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_id = rl_id[0];
          slot_out(0);
        end
      end
      default: begin
        // remove and requeue both start by taking the id out
        pos = find_task(a.id);
        if (pos >= rl_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          slot_out(pos);
          if (a.act == ACT_REQUEUE) slot_in(a.id, p);
        end
      end
    endcase
    r.head_valid  = (rl_count != 0);
    r.head_id     = (rl_count != 0) ? rl_id[0] : '0;
    r.entry_count = rl_count[COUNT_OUT_W-1:0];
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Input driver: offers queued actions, idles at random, predicts on transfer
  //--------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_blk
    logic stuck;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= ACT_INSERT;
    end else begin
      stuck = s_axis_tvalid && !s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(ready_list_step(on_bus));
        act_seen[on_bus.act]++;
        if (rl_count > peak_depth) peak_depth = rl_count;
      end
      // Hold the current offer until it is taken; otherwise pick the next one
      if (!stuck) begin
        if (queued_actions.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = queued_actions.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_DATA_W-ID_W-IN_PRIO_W){1'b0}}, on_bus.prio, on_bus.id};
          s_axis_tuser  <= on_bus.act;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Receiver ready: random stalls, plus one long hold-off that lets the
  // block back up and stall its input while the driver keeps offering
  //--------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  //--------------------------------------------------------------------------
  // Result monitor: every result transfer against the oldest expectation
  //--------------------------------------------------------------------------
  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : watch_blk
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      status_seen[m_axis_tuser]++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual tuser %0d tdata %h",
                 $realtime, m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status",      want.status,      m_axis_tuser);
        check_field("popped_id",   want.popped_id,   m_axis_tdata[3:0]);
        check_field("head_valid",  want.head_valid,  m_axis_tdata[4]);
        check_field("head_id",     want.head_id,     m_axis_tdata[8:5]);
        check_field("entry_count", want.entry_count, m_axis_tdata[13:9]);
      end
    end
  end

  //--------------------------------------------------------------------------
  // Watchdog: too long without any transfer means the block is hung
  //--------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $realtime, QUIET_LIMIT, awaited_results.size());
        $display("testbench: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus
  //--------------------------------------------------------------------------
  task automatic add_action(action_e act, int id, int prio);
    list_action_t a;
    a.act  = act;
    a.id   = id[ID_W-1:0];
    a.prio = prio[IN_PRIO_W-1:0];
    queued_actions.push_back(a);
    items_made++;
  endtask

  // Mostly tight ranges so equal priorities (FIFO order) come up often
  function automatic int pick_prio();
    case ($urandom_range(3))
      0:       return $urandom_range(3);
      1:       return $urandom_range(1) ? 255 : 0;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Every id inserted in shuffled order, then a few more: ends with a full list
  task automatic fill_burst();
    int order[QUEUE_DEPTH];
    int j, t;
    for (int i = 0; i < QUEUE_DEPTH; i++) order[i] = i;
    for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) add_action(ACT_INSERT, order[i], pick_prio());
    repeat ($urandom_range(3, 1)) add_action(ACT_INSERT, $urandom_range(15), pick_prio());
  endtask

  // Random actions; pop_pct steers the list toward empty or toward full
  task automatic mixed_burst(int n, int pop_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < pop_pct) add_action(ACT_POP, 0, $urandom_range(255));
      else if (r < pop_pct + (100 - pop_pct) / 3)
        add_action(ACT_REMOVE, $urandom_range(15), $urandom_range(255));
      else if (r < pop_pct + 2 * (100 - pop_pct) / 3)
        add_action(ACT_REQUEUE, $urandom_range(15), pick_prio());
      else add_action(ACT_INSERT, $urandom_range(15), pick_prio());
    end
  endtask

  task automatic random_until(int target);
    while (items_made < target) begin
      case ($urandom_range(3))
        0:       fill_burst();
        1:       mixed_burst($urandom_range(40, 10), 60);
        default: mixed_burst($urandom_range(40, 10), 20);
      endcase
    end
  endtask

  // Sender pause: nothing queued, nothing on the bus, nothing owed
  task automatic wait_all_done();
    while (queued_actions.size() > 0 || s_axis_tvalid || awaited_results.size() > 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty pop, null id, FIFO on equal priority, duplicate insert,
    // requeue behind an equal priority, absent remove and requeue, drain to empty
    add_action(ACT_POP,     0,  0);
    add_action(ACT_INSERT,  7,  255);
    add_action(ACT_INSERT,  0,  255);
    add_action(ACT_INSERT,  15, 0);
    add_action(ACT_INSERT,  7,  3);
    add_action(ACT_REQUEUE, 7,  0);
    add_action(ACT_REMOVE,  9,  255);
    add_action(ACT_REQUEUE, 9,  0);
    add_action(ACT_REMOVE,  15, 0);
    add_action(ACT_POP,     0,  255);
    add_action(ACT_POP,     15, 0);
    add_action(ACT_POP,     0,  0);
    add_action(ACT_INSERT,  0,  0);
    add_action(ACT_REQUEUE, 0,  255);
    add_action(ACT_REMOVE,  0,  0);
    add_action(ACT_POP,     0,  0);
    wait_all_done();

    // Random with idling on both sides, then a full stop for the sender
    fill_burst();
    random_until(500);
    wait_all_done();

    // No idling at all for a while
    steady = 1'b1;
    random_until(850);
    while (queued_actions.size() > 0) @(negedge clk_i);
    steady = 1'b0;

    // Long receiver hold-off while the driver keeps offering
    hold_req = 1'b1;
    random_until(TOTAL_ITEMS);
    wait_all_done();
    repeat (16) @(negedge clk_i);

    $display("Covered %0d transfers in, %0d results; insert %0d, pop %0d, remove %0d, requeue %0d.",
             items_made, results_seen, act_seen[ACT_INSERT], act_seen[ACT_POP],
             act_seen[ACT_REMOVE], act_seen[ACT_REQUEUE]);
    $display("Status ok %0d, empty %0d, dup/full %0d, not found %0d; deepest list %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_DUP_FULL],
             status_seen[ST_NOT_FOUND], peak_depth);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
